### src/mcua_pkg.sv
// Shared types and constants for the multi-channel underspeed alarm.
// No dependencies.
package mcua_pkg;

  localparam int CHANNELS = 5;
  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CH_W = 3;
  localparam int SPD_W = 16;
  localparam int CNT_W = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CH_W:0] CH_LIMIT = (CH_W + 1)'(CHANNELS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHANNELS - 1);
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPEED = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 3'd6;
  localparam logic [SPD_W-1:0] MIN_SPEED_RST = 16'd60;
  localparam logic [CNT_W-1:0] TIMEOUT_RST = 8'd4;

  localparam logic [1:0] REQ_REPORT = 2'd0;
  localparam logic [1:0] REQ_TICK = 2'd1;
  localparam logic [1:0] REQ_MASTER = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam logic [1:0] EV_DISPLAY = 2'd0;
  localparam logic [1:0] EV_BUZZER = 2'd1;
  localparam logic [1:0] EV_BEEP = 2'd2;

  typedef struct packed {
    logic [1:0] req_type;
    logic [CH_W-1:0] channel;
    logic [SPD_W-1:0] speed;
    logic master_enable;
  } req_word_t;

  typedef struct packed {
    logic [1:0] event_kind;
    logic [CH_W-1:0] event_channel;
    logic speed_shown;
    logic [SPD_W-1:0] speed_value;
    logic normal_flag;
    logic buzzer_master;
    logic buzzer_alarm;
    logic last;
  } evt_word_t;

  typedef struct packed {
    logic [SPD_W-1:0] thr;
    logic [SPD_W-1:0] min_valid;
    logic [CNT_W-1:0] timeout;
  } cfg_view_t;

endpackage

### src/multi_channel_underspeed_alarm.sv
// Five-channel underspeed alarm: one request word at a time, event words out.
// Report: accept, min compare, display, buzzer; master command: accept, master, buzzer;
// tick: one channel per cycle through the shared compare unit, then a beep if one fired.
// Busy until the last event word is registered; output stalls hold the sequencer.
// Synchronous reset: counters, latches and alarms cleared, master buzzer on.
module multi_channel_underspeed_alarm (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  mcua_pkg::req_word_t req,
  output logic evt_valid,
  input  logic evt_ready,
  output mcua_pkg::evt_word_t evt,
  input  logic cfg_we,
  input  logic [mcua_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mcua_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mcua_pkg::*;

  cfg_view_t view;
  logic [IDX_W-1:0] sel;

  mcua_cfg u_cfg (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .sel(sel),
    .view(view)
  );

  mcua_core u_core (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .evt_valid(evt_valid),
    .evt_ready(evt_ready),
    .evt(evt),
    .view(view),
    .sel(sel)
  );

  a_unused_type_idle: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && req.req_type == REQ_UNUSED) |=> req_ready)
    else $error("unused request type left sequencer busy");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && req.req_type != REQ_UNUSED) |=> !req_ready)
    else $error("ready while a request is in work");

  a_display_no_buzzer: assert property (@(posedge clk) disable iff (rst)
    (evt_valid && evt.event_kind == EV_DISPLAY) |-> (!evt.buzzer_master && !evt.buzzer_alarm))
    else $error("display word carries buzzer bits");

  a_beep_last: assert property (@(posedge clk) disable iff (rst)
    (evt_valid && evt.event_kind == EV_BEEP) |-> evt.last)
    else $error("beep word not marked last");

endmodule

### src/mcua_cfg.sv
// Configuration registers: channel thresholds, minimum valid speed, timeout.
// Depends on mcua_pkg.
module mcua_cfg (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [mcua_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mcua_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [mcua_pkg::IDX_W-1:0] sel,
  output mcua_pkg::cfg_view_t view
);
  import mcua_pkg::*;

  logic [SPD_W-1:0] thr [CHANNELS];
  logic [SPD_W-1:0] min_valid;
  logic [CNT_W-1:0] timeout;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        thr[i] <= '0;
      end
      min_valid <= MIN_SPEED_RST;
      timeout <= TIMEOUT_RST;
    end else if (cfg_we) begin
      if (cfg_index < CFG_MIN_SPEED) begin
        if ({1'b0, cfg_index} < (CFG_IDX_W + 1)'(CHANNELS)) begin
          thr[cfg_index[IDX_W-1:0]] <= cfg_data[SPD_W-1:0];
        end
      end else if (cfg_index == CFG_MIN_SPEED) begin
        min_valid <= cfg_data[SPD_W-1:0];
      end else if (cfg_index == CFG_TIMEOUT) begin
        timeout <= cfg_data[CNT_W-1:0];
      end
    end
  end

  assign view.thr = thr[sel];
  assign view.min_valid = min_valid;
  assign view.timeout = timeout;

endmodule

### src/mcua_core.sv
// Sequencer, channel state and shared compare unit; at most one event word per step.
// Depends on mcua_pkg.
module mcua_core (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  mcua_pkg::req_word_t req,
  output logic evt_valid,
  input  logic evt_ready,
  output mcua_pkg::evt_word_t evt,
  input  mcua_pkg::cfg_view_t view,
  output logic [mcua_pkg::IDX_W-1:0] sel
);
  import mcua_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RMIN = 3'd1;
  localparam logic [2:0] S_RDISP = 3'd2;
  localparam logic [2:0] S_TICK = 3'd3;
  localparam logic [2:0] S_BEEP = 3'd4;
  localparam logic [2:0] S_MASTER = 3'd5;
  localparam logic [2:0] S_BUZZ = 3'd6;

  logic [2:0] state;
  logic [CH_W-1:0] ch_r;
  logic [SPD_W-1:0] speed_r;
  logic men_r;
  logic blank_r;
  logic [IDX_W-1:0] idx;
  logic fired;
  logic [CNT_W-1:0] cnt [CHANNELS];
  logic [CHANNELS-1:0] seen;
  logic [CHANNELS-1:0] alarm;
  logic was_on;
  logic master;

  logic [SPD_W-1:0] op_a, op_b;
  logic lt, eq;
  logic [CNT_W-1:0] cnt_cur, cnt_inc;
  logic [IDX_W-1:0] ch_idx;
  logic [CHANNELS-1:0] clr_mask, alarm_kept;
  logic any_alarm, out_free, emit;
  evt_word_t ev;

  assign ch_idx = ch_r[IDX_W-1:0];
  assign sel = ch_idx;
  assign cnt_cur = cnt[idx];
  assign cnt_inc = cnt_cur + 1'b1;
  assign any_alarm = |alarm;
  assign out_free = !evt_valid || evt_ready;
  assign req_ready = (state == S_IDLE);

  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      clr_mask[i] = (ch_idx == IDX_W'(i));
    end
    alarm_kept = alarm & ~clr_mask;
  end

  // shared compare unit
  always_comb begin
    case (state)
      S_RDISP: begin
        op_a = speed_r;
        op_b = view.thr;
      end
      S_TICK: begin
        op_a = {{(SPD_W - CNT_W){1'b0}}, cnt_inc};
        op_b = {{(SPD_W - CNT_W){1'b0}}, view.timeout};
      end
      default: begin
        op_a = speed_r;
        op_b = view.min_valid;
      end
    endcase
    lt = op_a < op_b;
    eq = op_a == op_b;
  end

  always_comb begin
    ev = '0;
    emit = 1'b0;
    case (state)
      S_RDISP: begin
        emit = 1'b1;
        ev.event_kind = EV_DISPLAY;
        ev.event_channel = ch_r;
        if (blank_r) begin
          ev.normal_flag = 1'b1;
          ev.last = !(any_alarm || was_on);
        end else begin
          ev.speed_shown = 1'b1;
          ev.speed_value = speed_r;
          ev.normal_flag = !lt;
          ev.last = !((|alarm_kept) || lt || was_on);
        end
      end
      S_TICK: begin
        emit = (cnt_cur != CNT_MAX) && eq && seen[idx];
        ev.event_kind = EV_DISPLAY;
        ev.event_channel = CH_W'(idx);
        ev.normal_flag = 1'b1;
      end
      S_BEEP: begin
        emit = 1'b1;
        ev.event_kind = EV_BEEP;
        ev.buzzer_master = master;
        ev.buzzer_alarm = was_on;
        ev.last = 1'b1;
      end
      S_MASTER: begin
        emit = 1'b1;
        ev.event_kind = EV_BUZZER;
        ev.buzzer_master = men_r;
        ev.buzzer_alarm = was_on;
        ev.last = !(any_alarm || was_on);
      end
      S_BUZZ: begin
        emit = any_alarm || was_on;
        ev.event_kind = EV_BUZZER;
        ev.buzzer_master = master;
        ev.buzzer_alarm = any_alarm;
        ev.last = 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx <= '0;
      fired <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        cnt[i] <= '0;
      end
      seen <= '0;
      alarm <= '0;
      was_on <= 1'b0;
      master <= 1'b1;
      evt_valid <= 1'b0;
    end else begin
      if (emit && out_free) begin
        evt_valid <= 1'b1;
        evt <= ev;
      end else if (evt_ready) begin
        evt_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (req_valid) begin
            ch_r <= req.channel;
            speed_r <= req.speed;
            men_r <= req.master_enable;
            idx <= '0;
            fired <= 1'b0;
            case (req.req_type)
              REQ_REPORT: begin
                state <= ({1'b0, req.channel} < CH_LIMIT) ? S_RMIN : S_BUZZ;
              end
              REQ_TICK: begin
                state <= S_TICK;
              end
              REQ_MASTER: begin
                state <= S_MASTER;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_RMIN: begin
          blank_r <= lt;
          state <= S_RDISP;
        end
        S_RDISP: begin
          if (out_free) begin
            seen[ch_idx] <= 1'b1;
            if (!blank_r) begin
              cnt[ch_idx] <= '0;
              alarm[ch_idx] <= lt;
            end
            state <= S_BUZZ;
          end
        end
        S_TICK: begin
          if (out_free) begin
            if (cnt_cur != CNT_MAX) begin
              cnt[idx] <= cnt_inc;
            end
            if (emit) begin
              fired <= 1'b1;
            end
            if (idx == LAST_IDX) begin
              state <= (fired || emit) ? S_BEEP : S_IDLE;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        S_BEEP: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        S_MASTER: begin
          if (out_free) begin
            master <= men_r;
            state <= S_BUZZ;
          end
        end
        S_BUZZ: begin
          if (out_free) begin
            was_on <= any_alarm;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
